>>> rtl/dtz_pkg.sv
// ----------------------------------------------------------------------------
// dtz_pkg
// Shared types and constants of the touch dead-zone filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtz_pkg;

   // field widths
   localparam int TimeW   = 48;
   localparam int PosW    = 16;
   localparam int MsW     = 16;
   localparam int SizeW   = 12;
   localparam int CmdW    = 2;
   localparam int ProdW   = SizeW + MsW;
   localparam int DivBits = ProdW + 1;
   localparam int CntW    = $clog2(DivBits);
   localparam int AddrW   = 5;
   localparam int DataW   = 32;

   // queue between front and back
   localparam int QDepth = 2;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // command codes
   localparam logic [CmdW-1:0] CMD_POKE  = 2'd0;
   localparam logic [CmdW-1:0] CMD_TOUCH = 2'd1;

   // register indexes
   localparam logic [2:0] REG_HOLD     = 3'd0;
   localparam logic [2:0] REG_DECAY    = 3'd1;
   localparam logic [2:0] REG_SIZE_MIN = 3'd2;
   localparam logic [2:0] REG_SIZE_MAX = 3'd3;
   localparam logic [2:0] REG_VERTICAL = 3'd4;
   localparam logic [2:0] REG_FLASH    = 3'd5;

   typedef struct packed {
      logic [MsW-1:0]   hold_time;
      logic [MsW-1:0]   decay_time;
      logic [SizeW-1:0] size_min;
      logic [SizeW-1:0] size_max;
      logic             vertical_mode;
      logic             flash_on_capture;
   } cfg_type;

   typedef enum logic {
      KIND_FIXED,
      KIND_RAMP
   } kind_type;

   // one classified item
   typedef struct packed {
      kind_type         kind;
      logic [SizeW-1:0] depth;
      logic [MsW-1:0]   elapsed;
      logic [PosW-1:0]  pos_x;
      logic [PosW-1:0]  pos_y;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_LOAD,
      B_DIV,
      B_FINISH,
      B_OUT
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/dtz_front.sv
// ----------------------------------------------------------------------------
// dtz_front
// Accepts beats, tracks the last poke time and classifies each touch down.
// ----------------------------------------------------------------------------
`default_nettype none

module dtz_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dtz_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dtz_pkg::CmdW-1:0]      req_command,
   input  wire logic [dtz_pkg::TimeW-1:0]     req_event_time,
   input  wire logic [dtz_pkg::PosW-1:0]      req_pos_x,
   input  wire logic [dtz_pkg::PosW-1:0]      req_pos_y,
   input  wire dtz_pkg::q_status_type         q_status,
   output logic                               q_push,
   output dtz_pkg::entry_type                 q_entry
);

   logic                           st_valid_ff, st_valid_in;
   logic [dtz_pkg::CmdW-1:0]       st_cmd_ff;
   logic [dtz_pkg::TimeW-1:0]      st_time_ff;
   logic [dtz_pkg::PosW-1:0]       st_x_ff, st_y_ff;
   logic [dtz_pkg::TimeW-1:0]      last_poke_ff, last_poke_in;

   logic                           accept;
   logic [dtz_pkg::TimeW:0]        dt;
   logic                           dt_neg, dt_high;
   logic [dtz_pkg::MsW:0]          dt_low, end_time, elapsed_full;
   logic                           past_end, before_hold;

   // stage handshake
   assign req_stall   = st_valid_ff & q_status.full;
   assign accept      = req_valid & ~req_stall;
   assign q_push      = st_valid_ff & ~q_status.full;
   assign st_valid_in = accept | (st_valid_ff & ~q_push);

   // elapsed time since the last poke, as a signed difference
   assign dt           = {1'b0, st_time_ff} - {1'b0, last_poke_ff};
   assign dt_neg       = dt[dtz_pkg::TimeW];
   assign dt_high      = |dt[dtz_pkg::TimeW-1:dtz_pkg::MsW+1];
   assign dt_low       = dt[dtz_pkg::MsW:0];
   assign end_time     = {1'b0, cfg.hold_time} + {1'b0, cfg.decay_time};
   assign past_end     = ~dt_neg & (dt_high | (dt_low > end_time));
   assign before_hold  = dt_neg | (~dt_high & (dt_low < {1'b0, cfg.hold_time}));
   assign elapsed_full = dt_low - {1'b0, cfg.hold_time};

   // classify the staged beat
   always_comb begin
      q_entry.kind    = dtz_pkg::KIND_FIXED;
      q_entry.depth   = '0;
      q_entry.elapsed = elapsed_full[dtz_pkg::MsW-1:0];
      q_entry.pos_x   = st_x_ff;
      q_entry.pos_y   = st_y_ff;
      if (st_cmd_ff == dtz_pkg::CMD_TOUCH && cfg.size_max != '0) begin
         if (past_end) begin
            q_entry.depth = cfg.size_min;
         end else if (before_hold || cfg.decay_time == '0) begin
            q_entry.depth = cfg.size_max;
         end else begin
            q_entry.kind = dtz_pkg::KIND_RAMP;
         end
      end
   end

   // poke bookkeeping
   assign last_poke_in = (q_push && st_cmd_ff == dtz_pkg::CMD_POKE) ? st_time_ff : last_poke_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         last_poke_ff <= '0;
      end else begin
         st_valid_ff  <= st_valid_in;
         last_poke_ff <= last_poke_in;
      end
      if (accept) begin
         st_cmd_ff  <= req_command;
         st_time_ff <= req_event_time;
         st_x_ff    <= req_pos_x;
         st_y_ff    <= req_pos_y;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dtz_queue.sv
// ----------------------------------------------------------------------------
// dtz_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dtz_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire dtz_pkg::entry_type    push_entry,
   input  wire logic                  pop,
   output dtz_pkg::entry_type         head_entry,
   output dtz_pkg::q_status_type      status
);

   dtz_pkg::entry_type              slot_ff [dtz_pkg::QDepth];
   logic [dtz_pkg::QPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dtz_pkg::QPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dtz_pkg::QCntW-1:0]       count_ff, count_in;
   logic                            do_push, do_pop;

   assign status.valid = count_ff != '0;
   assign status.full  = count_ff == dtz_pkg::QCntW'(dtz_pkg::QDepth);
   assign head_entry   = slot_ff[rd_ptr_ff];

   assign do_push = push & ~status.full;
   assign do_pop  = pop & status.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dtz_pkg::QPtrW'(dtz_pkg::QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dtz_pkg::QPtrW'(dtz_pkg::QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + dtz_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - dtz_pkg::QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dtz_back.sv
// ----------------------------------------------------------------------------
// dtz_back
// Works out the ramp depth with a shared multiply and a bit-serial divide,
// then runs the consume test and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dtz_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dtz_pkg::cfg_type              cfg,
   input  wire dtz_pkg::q_status_type         q_status,
   input  wire dtz_pkg::entry_type            q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_consumed,
   output logic [dtz_pkg::SizeW-1:0]          rsp_zone_depth,
   output logic                               rsp_flash_request
);

   dtz_pkg::back_state_type             state_ff, state_in;
   logic [dtz_pkg::SizeW-1:0]           depth_ff, depth_in;
   logic [dtz_pkg::MsW-1:0]             elapsed_ff, elapsed_in;
   logic [dtz_pkg::PosW-1:0]            x_ff, x_in, y_ff, y_in;
   logic [dtz_pkg::ProdW-1:0]           prod_ff, prod_in;
   logic [dtz_pkg::DivBits-1:0]         div_ff, div_in;
   logic [dtz_pkg::MsW-1:0]             rem_ff, rem_in;
   logic [dtz_pkg::CntW-1:0]            cnt_ff, cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_consumed_ff, rsp_consumed_in;
   logic [dtz_pkg::SizeW-1:0]           rsp_depth_ff, rsp_depth_in;
   logic                                rsp_flash_ff, rsp_flash_in;

   logic                                span_neg;
   logic [dtz_pkg::SizeW-1:0]           span_mag;
   logic [dtz_pkg::MsW:0]               rem_shift;
   logic                                rem_ge;
   logic [dtz_pkg::PosW-1:0]            limit;
   logic                                hit;
   logic                                out_free;
   logic                                last_step;

   // span between the two sizes, as sign and magnitude
   assign span_neg = cfg.size_min > cfg.size_max;
   assign span_mag = span_neg ? cfg.size_min - cfg.size_max : cfg.size_max - cfg.size_min;

   // one restoring divide step
   assign rem_shift = {rem_ff, div_ff[dtz_pkg::DivBits-1]};
   assign rem_ge    = rem_shift >= {1'b0, cfg.decay_time};
   assign last_step = cnt_ff == dtz_pkg::CntW'(dtz_pkg::DivBits - 1);

   // consume test
   assign limit = {depth_ff, 4'b0000};
   assign hit   = (y_ff < limit) | (cfg.vertical_mode & (x_ff < limit));

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtz_pkg::B_IDLE: begin
            if (q_status.valid) begin
               state_in = (q_entry.kind == dtz_pkg::KIND_RAMP) ? dtz_pkg::B_MUL : dtz_pkg::B_OUT;
            end
         end
         dtz_pkg::B_MUL:    state_in = dtz_pkg::B_LOAD;
         dtz_pkg::B_LOAD:   state_in = dtz_pkg::B_DIV;
         dtz_pkg::B_DIV: begin
            if (last_step) begin
               state_in = dtz_pkg::B_FINISH;
            end
         end
         dtz_pkg::B_FINISH: state_in = dtz_pkg::B_OUT;
         dtz_pkg::B_OUT: begin
            if (out_free) begin
               state_in = dtz_pkg::B_IDLE;
            end
         end
         default:           state_in = dtz_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop           = 1'b0;
      depth_in        = depth_ff;
      elapsed_in      = elapsed_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      prod_in         = prod_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      rsp_consumed_in = rsp_consumed_ff;
      rsp_depth_in    = rsp_depth_ff;
      rsp_flash_in    = rsp_flash_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      case (state_ff)
         dtz_pkg::B_IDLE: begin
            if (q_status.valid) begin
               q_pop      = 1'b1;
               depth_in   = q_entry.depth;
               elapsed_in = q_entry.elapsed;
               x_in       = q_entry.pos_x;
               y_in       = q_entry.pos_y;
            end
         end
         dtz_pkg::B_MUL: begin
            prod_in = dtz_pkg::ProdW'(span_mag) * dtz_pkg::ProdW'(elapsed_ff);
         end
         dtz_pkg::B_LOAD: begin
            // when the span is not negative, bias by decay - 1 so that the quotient rounds up
            div_in = {1'b0, prod_ff}
                   + (span_neg ? '0
                               : dtz_pkg::DivBits'(cfg.decay_time - dtz_pkg::MsW'(1)));
            rem_in = '0;
            cnt_in = '0;
         end
         dtz_pkg::B_DIV: begin
            rem_in = rem_ge ? rem_shift[dtz_pkg::MsW-1:0] - cfg.decay_time
                            : rem_shift[dtz_pkg::MsW-1:0];
            div_in = {div_ff[dtz_pkg::DivBits-2:0], rem_ge};
            cnt_in = cnt_ff + dtz_pkg::CntW'(1);
         end
         dtz_pkg::B_FINISH: begin
            depth_in = span_neg ? cfg.size_max + div_ff[dtz_pkg::SizeW-1:0]
                                : cfg.size_max - div_ff[dtz_pkg::SizeW-1:0];
         end
         dtz_pkg::B_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_consumed_in = hit;
               rsp_depth_in    = depth_ff;
               rsp_flash_in    = hit & cfg.flash_on_capture;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtz_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      depth_ff        <= depth_in;
      elapsed_ff      <= elapsed_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      prod_ff         <= prod_in;
      div_ff          <= div_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      rsp_consumed_ff <= rsp_consumed_in;
      rsp_depth_ff    <= rsp_depth_in;
      rsp_flash_ff    <= rsp_flash_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_consumed      = rsp_consumed_ff;
   assign rsp_zone_depth    = rsp_depth_ff;
   assign rsp_flash_request = rsp_flash_ff;

endmodule

`default_nettype wire

>>> rtl/touch_dead_zone_filter_unit.sv
// ----------------------------------------------------------------------------
// touch_dead_zone_filter_unit
// Edge dead-zone filter for touch events with a depth that decays after a poke.
// ----------------------------------------------------------------------------
// Every request beat gives exactly one response beat, in order. A poke or other
// action goes through the front stage and queue straight to the back end output;
// a touch down whose elapsed time falls in the decay window also runs the 29-step
// bit-serial divider in the back end that scales the size span by the elapsed
// time over the decay time. The front end keeps taking beats while the back end
// works, until its two-entry queue fills. The user must write registers over the
// APB port only while no beat is in flight; the block does not enforce this.
`default_nettype none

module touch_dead_zone_filter_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dtz_pkg::CmdW-1:0]      req_command,
   input  wire logic [dtz_pkg::TimeW-1:0]     req_event_time,
   input  wire logic [dtz_pkg::PosW-1:0]      req_pos_x,
   input  wire logic [dtz_pkg::PosW-1:0]      req_pos_y,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_consumed,
   output logic [dtz_pkg::SizeW-1:0]          rsp_zone_depth,
   output logic                               rsp_flash_request,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [dtz_pkg::AddrW-1:0]     paddr,
   input  wire logic [dtz_pkg::DataW-1:0]     pwdata,
   output logic [dtz_pkg::DataW-1:0]          prdata,
   output logic                               pready
);

   dtz_pkg::cfg_type         cfg_ff, cfg_in;
   logic                     wr_en;
   logic [2:0]               reg_index;
   dtz_pkg::q_status_type    q_status;
   logic                     q_push, q_pop;
   dtz_pkg::entry_type       push_entry, head_entry;

   // register writes
   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite & pready;
   assign reg_index = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            dtz_pkg::REG_HOLD:     cfg_in.hold_time        = pwdata[dtz_pkg::MsW-1:0];
            dtz_pkg::REG_DECAY:    cfg_in.decay_time       = pwdata[dtz_pkg::MsW-1:0];
            dtz_pkg::REG_SIZE_MIN: cfg_in.size_min         = pwdata[dtz_pkg::SizeW-1:0];
            dtz_pkg::REG_SIZE_MAX: cfg_in.size_max         = pwdata[dtz_pkg::SizeW-1:0];
            dtz_pkg::REG_VERTICAL: cfg_in.vertical_mode    = pwdata[0];
            dtz_pkg::REG_FLASH:    cfg_in.flash_on_capture = pwdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_index)
         dtz_pkg::REG_HOLD:     prdata = dtz_pkg::DataW'(cfg_ff.hold_time);
         dtz_pkg::REG_DECAY:    prdata = dtz_pkg::DataW'(cfg_ff.decay_time);
         dtz_pkg::REG_SIZE_MIN: prdata = dtz_pkg::DataW'(cfg_ff.size_min);
         dtz_pkg::REG_SIZE_MAX: prdata = dtz_pkg::DataW'(cfg_ff.size_max);
         dtz_pkg::REG_VERTICAL: prdata = dtz_pkg::DataW'(cfg_ff.vertical_mode);
         dtz_pkg::REG_FLASH:    prdata = dtz_pkg::DataW'(cfg_ff.flash_on_capture);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept and classify
   dtz_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_event_time (req_event_time),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // queue between the two ends
   dtz_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // back end: depth and consume test
   dtz_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .q_entry           (head_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_consumed      (rsp_consumed),
      .rsp_zone_depth    (rsp_zone_depth),
      .rsp_flash_request (rsp_flash_request)
   );

   // checks
   a_flash_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flash_request |-> rsp_consumed)
      else $error("flash request without a consumed touch");

   a_hit_needs_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_consumed |-> rsp_zone_depth != '0)
      else $error("touch consumed by a zone of zero depth");

   a_flash_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cfg_ff.flash_on_capture |-> !rsp_flash_request)
      else $error("flash request while flash is disabled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && q_status == '0)
      else $error("response or queue not empty after reset");

endmodule

`default_nettype wire
